// ===== hdl/bmia_pkg.sv =====
package bmia_pkg;

	// Bitmap geometry
	localparam int INDEX_COUNT = 256;
	localparam int WORD_BITS   = 32;
	localparam int WORD_COUNT  = (INDEX_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_W       = 5;
	localparam int IDX_W       = WORD_W + BIT_W + 1;

	// Port field widths
	localparam int MODE_W   = 1;
	localparam int FREE_W   = 12;
	localparam int GRANT_W  = 9;
	localparam int STATUS_W = 2;
	localparam int FWORD_W  = FREE_W - BIT_W;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_W-1:0]    word_idx_t;
	typedef logic [BIT_W-1:0]     bit_pos_t;

	// Find-first-set result handed back to the sequencer
	typedef struct packed {
		logic     empty;
		bit_pos_t pos;
		word_t    cleared;
	} ffs_res_t;

endpackage

// ===== hdl/bitmap_index_allocator_top.sv =====
// Free: result strobe (done) rises in the cycle after the request is accepted; busy stays low.
// Allocate: one bitmap word probed per cycle through the shared find-first-set
//   unit, the hint word first if one is held, then a cyclic scan; done
//   rises in the cycle after the last probe; busy is high while probing.
// Results are strobed for one cycle; the receiver cannot stall the block.
// Reset (arst_n low): all indexes free, no hint, scan start at word 0.
module bitmap_index_allocator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bmia_pkg::MODE_W-1:0]        mode,
	input  logic [bmia_pkg::FREE_W-1:0]        free_index,
	output logic                               done,
	output logic [bmia_pkg::GRANT_W-1:0]       granted_index,
	output logic [bmia_pkg::STATUS_W-1:0]      status
);
	import bmia_pkg::*;

	typedef enum logic {ST_IDLE, ST_PROBE} state_t;

	state_t                state_q;
	word_idx_t             cur_q;
	word_idx_t             cnt_q;
	logic                  on_hint_q;
	word_idx_t             hint_q;
	logic                  hint_valid_q;
	word_idx_t             scan_q;
	logic                  done_q;
	logic [GRANT_W-1:0]    grant_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  accept;
	logic [FREE_W-1:0]     k_m1;
	logic [FWORD_W-1:0]    free_word;
	bit_pos_t              free_bit;
	logic                  free_ok;
	word_idx_t             rd_addr;
	word_t                 rd_data;
	ffs_res_t              ffs;
	logic [IDX_W-1:0]      idx_full;
	logic                  grant_ok;
	logic                  wr_en;
	word_idx_t             wr_addr;
	word_t                 wr_data;

	// Decode the word and bit of a free request
	assign accept    = start && !busy;
	assign k_m1      = free_index - FREE_W'(1);
	assign free_word = k_m1[FREE_W-1:BIT_W];
	assign free_bit  = k_m1[BIT_W-1:0];
	assign free_ok   = (free_index != '0) && (int'(free_word) < WORD_COUNT);

	// Read the free word when idle, the probed word otherwise
	assign rd_addr = (state_q == ST_IDLE) ? free_word[WORD_W-1:0] : cur_q;

	bmia_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bmia_ffs u_ffs (
		.word (rd_data),
		.res  (ffs)
	);

	// Form the 1-based index and check it against the index count
	assign idx_full = IDX_W'({cur_q, ffs.pos}) + IDX_W'(1);
	assign grant_ok = int'(idx_full) <= INDEX_COUNT;

	// Write back a freed bit or a taken bit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = ffs.cleared;
		if (state_q == ST_IDLE) begin
			wr_en   = accept && (mode == MODE_FREE) && free_ok;
			wr_addr = free_word[WORD_W-1:0];
			wr_data = rd_data | (word_t'(1) << free_bit);
		end else begin
			wr_en = !ffs.empty;
		end
	end

	// Sequence the hint probe and the cyclic scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			on_hint_q    <= 1'b0;
			hint_q       <= '0;
			hint_valid_q <= 1'b0;
			scan_q       <= '0;
			done_q       <= 1'b0;
			grant_q      <= '0;
			status_q     <= STATUS_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_FREE) begin
							done_q   <= 1'b1;
							grant_q  <= '0;
							status_q <= free_ok ? STATUS_OK : STATUS_RANGE;
							if (free_ok) begin
								hint_q       <= free_word[WORD_W-1:0];
								hint_valid_q <= 1'b1;
							end
						end else begin
							state_q   <= ST_PROBE;
							on_hint_q <= hint_valid_q;
							cur_q     <= hint_valid_q ? hint_q : scan_q;
							cnt_q     <= '0;
						end
					end
				end
				ST_PROBE: begin
					if (!ffs.empty) begin
						done_q   <= 1'b1;
						grant_q  <= grant_ok ? GRANT_W'(idx_full) : '0;
						status_q <= grant_ok ? STATUS_OK : STATUS_NONE;
						state_q  <= ST_IDLE;
						if (on_hint_q) begin
							if (ffs.cleared == '0) begin
								hint_valid_q <= 1'b0;
							end
						end else begin
							scan_q       <= cur_q;
							hint_q       <= cur_q;
							hint_valid_q <= (ffs.cleared != '0);
						end
					end else if (on_hint_q) begin
						// Drop a stale hint and fall back to the scan
						hint_valid_q <= 1'b0;
						on_hint_q    <= 1'b0;
						cur_q        <= scan_q;
						cnt_q        <= '0;
					end else if (cnt_q == WORD_W'(WORD_COUNT - 1)) begin
						done_q   <= 1'b1;
						grant_q  <= '0;
						status_q <= STATUS_NONE;
						state_q  <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + WORD_W'(1);
						cur_q <= (cur_q == WORD_W'(WORD_COUNT - 1)) ? '0 : cur_q + WORD_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign granted_index = grant_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	// A failed request never carries an index
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STATUS_OK) |-> granted_index == '0)
		else $error("failed request carries an index");

	// A free request answers in the next cycle
	a_free_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == MODE_FREE) |=> done && (granted_index == '0))
		else $error("free result missing");

	// The result strobe never rises while the block is busy probing
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still probing");

	// The hint probe only runs on the first probe cycle
	a_hint_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy && on_hint_q |-> cnt_q == '0)
		else $error("hint probe after scan began");
`endif

endmodule

// ===== hdl/bmia_ffs.sv =====
module bmia_ffs (
	input  bmia_pkg::word_t    word,
	output bmia_pkg::ffs_res_t res
);
	import bmia_pkg::*;

	bit_pos_t pos;

	// Priority-encode the lowest set bit
	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) begin
				pos = BIT_W'(i);
			end
		end
	end

	// Drop the lowest set bit and flag an empty word
	assign res.empty   = (word == '0);
	assign res.pos     = pos;
	assign res.cleared = word & (word - word_t'(1));

endmodule

// ===== hdl/bmia_map.sv =====
module bmia_map (
	input  logic                clk,
	input  logic                arst_n,
	input  bmia_pkg::word_idx_t rd_addr,
	output bmia_pkg::word_t     rd_data,
	input  logic                wr_en,
	input  bmia_pkg::word_idx_t wr_addr,
	input  bmia_pkg::word_t     wr_data
);
	import bmia_pkg::*;

	word_t map_q [WORD_COUNT];

	// Hold the bitmap; reset marks every index free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				map_q[i] <= '1;
			end
		end else if (wr_en) begin
			map_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = map_q[rd_addr];

endmodule

// ===== test/bmia_grant_checker.sv =====
module bmia_grant_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [bmia_pkg::MODE_W-1:0]   mode,
	input  logic [bmia_pkg::FREE_W-1:0]   free_index,
	input  logic                          done,
	input  logic [bmia_pkg::GRANT_W-1:0]  granted_index,
	input  logic [bmia_pkg::STATUS_W-1:0] status,
	output int                            errors,
	output int                            pending
);
	import bmia_pkg::*;

	typedef struct packed {
		logic [GRANT_W-1:0]  grant;
		logic [STATUS_W-1:0] code;
	} grant_rec_t;

	// Shadow copy of the allocator state
	logic [WORD_BITS-1:0] slot_map [WORD_COUNT];
	int                   hint_word;
	bit                   hint_ok;
	int                   scan_word;

	grant_rec_t awaited_grants [$];
	grant_rec_t rec_new;
	grant_rec_t rec_old;

	// Clear the lowest free bit of a bitmap word and return its 1-based index
	task automatic take_lowest(input int w, output int idx);
		int pos;
		begin
			pos = 0;
			while (pos < WORD_BITS - 1 && !slot_map[w][pos])
				pos++;
			slot_map[w][pos] = 1'b0;
			idx = w * WORD_BITS + pos + 1;
		end
	endtask

	// Apply one request word to the shadow state and form its result word
	task automatic predict_grant(input logic [MODE_W-1:0] m, input logic [FREE_W-1:0] k,
			output grant_rec_t rec);
		int w;
		int idx;
		bit found;
		begin
			rec.grant = '0;
			rec.code  = STATUS_OK;
			idx       = 0;
			found     = 1'b0;
			if (m == MODE_FREE) begin
				// Release: set the bit (never toggle) and make its word the hint
				if (k == '0 || ((int'(k) - 1) / WORD_BITS) >= WORD_COUNT) begin
					rec.code = STATUS_RANGE;
				end else begin
					w = (int'(k) - 1) / WORD_BITS;
					slot_map[w][(int'(k) - 1) % WORD_BITS] = 1'b1;
					hint_word = w;
					hint_ok   = 1'b1;
				end
			end else begin
				if (hint_ok && slot_map[hint_word] != '0) begin
					// Hint hit: drop the hint once the word runs dry
					take_lowest(hint_word, idx);
					if (slot_map[hint_word] == '0)
						hint_ok = 1'b0;
					found = 1'b1;
				end else begin
					// Cyclic scan from the word of the last scan grant
					hint_ok = 1'b0;
					w = (scan_word < WORD_COUNT) ? scan_word : 0;
					for (int n = 0; n < WORD_COUNT && !found; n++) begin
						if (slot_map[w] != '0) begin
							take_lowest(w, idx);
							scan_word = w;
							if (slot_map[w] != '0) begin
								hint_word = w;
								hint_ok   = 1'b1;
							end
							found = 1'b1;
						end else begin
							w = (w + 1) % WORD_COUNT;
						end
					end
				end
				if (!found || idx > INDEX_COUNT)
					rec.code = STATUS_NONE;
				else
					rec.grant = idx[GRANT_W-1:0];
			end
		end
	endtask

	// Watch both channels; compare results first, then record the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++)
				slot_map[i] = '1;
			hint_word = 0;
			hint_ok   = 1'b0;
			scan_word = 0;
			awaited_grants.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (awaited_grants.size() == 0) begin
					if (errors < 10)
						$display("checker: result word with none awaited: index %0d status %0d",
							granted_index, status);
					errors++;
				end else begin
					rec_old = awaited_grants.pop_front();
					if (granted_index !== rec_old.grant || status !== rec_old.code) begin
						if (errors < 10)
							$display("checker: expected index %0d status %0d, got index %0d status %0d",
								rec_old.grant, rec_old.code, granted_index, status);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				predict_grant(mode, free_index, rec_new);
				awaited_grants.push_back(rec_new);
			end
			pending = awaited_grants.size();
		end
	end

endmodule

// ===== test/tb.sv =====
module tb;
	import bmia_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 200000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [MODE_W-1:0]   mode;
	logic [FREE_W-1:0]   free_index;
	logic                done;
	logic [GRANT_W-1:0]  granted_index;
	logic [STATUS_W-1:0] status;
	int                  errors;
	int                  pending;
	int                  cycles;

	bitmap_index_allocator_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.free_index    (free_index),
		.done          (done),
		.granted_index (granted_index),
		.status        (status)
	);

	bmia_grant_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.free_index    (free_index),
		.done          (done),
		.granted_index (granted_index),
		.status        (status),
		.errors        (errors),
		.pending       (pending)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort a hung run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Present one request word and hold it until the block takes it
	task automatic issue(input logic [MODE_W-1:0] m, input logic [FREE_W-1:0] k);
		begin
			start      <= 1'b1;
			mode       <= m;
			free_index <= k;
			do
				@(posedge clk);
			while (busy);
			@(negedge clk);
		end
	endtask

	// Release index: mostly in range, sometimes zero or past the bitmap
	function automatic logic [FREE_W-1:0] pick_index();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 80)
				return FREE_W'($urandom_range(1, INDEX_COUNT));
			else if (r < 90)
				return FREE_W'($urandom_range(INDEX_COUNT + 1, (1 << FREE_W) - 1));
			else if (r < 94)
				return '0;
			else if (r < 97)
				return '1;
			else
				return FREE_W'(INDEX_COUNT + $urandom_range(0, 1));
		end
	endfunction

	initial begin
		int burst_left;
		int seg_left;
		int alloc_pct;
		int done_items;
		start      = 1'b0;
		mode       = MODE_ALLOC;
		free_index = '0;
		arst_n     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: scan grant, hint hits, range edges, repeat free, word 0 as hint
		issue(MODE_ALLOC, '0);
		issue(MODE_ALLOC, '0);
		issue(MODE_ALLOC, '1);
		issue(MODE_FREE, FREE_W'(1));
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, FREE_W'(2));
		issue(MODE_FREE, FREE_W'(2));
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, '0);
		issue(MODE_FREE, '1);
		issue(MODE_FREE, FREE_W'(INDEX_COUNT + 1));
		issue(MODE_FREE, FREE_W'(INDEX_COUNT));
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, FREE_W'(WORD_BITS));
		issue(MODE_FREE, FREE_W'(WORD_BITS + 1));
		issue(MODE_ALLOC, '0);
		issue(MODE_ALLOC, '0);
		issue(MODE_ALLOC, '0);
		issue(MODE_FREE, FREE_W'(2048));
		issue(MODE_FREE, FREE_W'(INDEX_COUNT - WORD_BITS + 1));
		issue(MODE_ALLOC, '0);

		// Random: a long drain to exhaustion first, then mixed segments
		burst_left = 0;
		seg_left   = 300;
		alloc_pct  = 98;
		for (done_items = 0; done_items < RANDOM_ITEMS; done_items++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 100);
				case ($urandom_range(0, 3))
					0: alloc_pct = 95;
					1: alloc_pct = 60;
					2: alloc_pct = 40;
					default: alloc_pct = 15;
				endcase
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end
			if ($urandom_range(0, 99) < alloc_pct)
				issue(MODE_ALLOC, FREE_W'($urandom()));
			else
				issue(MODE_FREE, pick_index());
			burst_left--;
			seg_left--;
		end
		start <= 1'b0;

		// Drain outstanding results, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bmia_pkg.sv
hdl/bmia_ffs.sv
hdl/bmia_map.sv
hdl/bitmap_index_allocator_top.sv
test/bmia_grant_checker.sv
test/tb.sv
